[design/rsg_pkg.sv]
`timescale 1ns / 1ps

package rsg_pkg;

  localparam int DIST_W = 16;
  localparam int IDX_W = 12;
  localparam int PIX_W = 14;
  localparam int ANG_W = 16;
  localparam int CTR_W = 11;
  localparam int K_W = 8;

  // Entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Odd sine polynomial in Q30, quadrant angle scaled to Q16
  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = -32'sd693598668;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C7 = -32'sd5026994;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;

  typedef enum logic [2:0] {
    REG_RANGE_LOW   = 3'd0,
    REG_RANGE_HIGH  = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_GRID_CENTER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] range_low;
    logic [DIST_W-1:0] range_high;
    logic [ANG_W-1:0]  angle_step;
    logic [CTR_W-1:0]  grid_center;
  } rsg_cfg_t;

  typedef struct packed {
    logic             load;
    logic [ANG_W-1:0] value;
  } rsg_start_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              in_window;
    logic              last;
    logic [IDX_W-1:0]  index;
    logic [ANG_W-1:0]  angle;
  } rsg_item_t;

endpackage

[design/rsg_fifo.sv]
`timescale 1ns / 1ps

module rsg_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsg_pkg::rsg_item_t push_item,
  input  logic               pop,
  output rsg_pkg::rsg_item_t head_item,
  output logic               full,
  output logic               not_empty
);
  import rsg_pkg::*;

  rsg_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/rsg_front.sv]
`timescale 1ns / 1ps

module rsg_front #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_distance,
  input  logic                in_scan_last,
  input  rsg_pkg::rsg_cfg_t   cfg,
  input  rsg_pkg::rsg_start_t start_wr,
  input  logic                queue_full,
  output logic                push,
  output rsg_pkg::rsg_item_t  push_item
);
  import rsg_pkg::*;

  localparam int CW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [CW-1:0]    count_r, count_nxt;
  logic [ANG_W-1:0] angle_r, angle_nxt;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.distance  = in_distance;
    push_item.in_window = (in_distance >= cfg.range_low) && (in_distance <= cfg.range_high);
    push_item.last      = in_scan_last;
    push_item.index     = IDX_W'(count_r);
    push_item.angle     = angle_r;
  end

  // Restart the scan on its last sample; otherwise advance index and angle
  always_comb begin
    count_nxt = count_r;
    angle_nxt = angle_r;
    if (push) begin
      if (in_scan_last) begin
        count_nxt = '0;
        angle_nxt = start_wr.value;
      end else begin
        count_nxt = (count_r == CW'(MAX_SAMPLES - 1)) ? '0 : CW'(count_r + 1'b1);
        angle_nxt = ANG_W'(angle_r + cfg.angle_step);
      end
    end else if (start_wr.load && (count_r == '0)) begin
      angle_nxt = start_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      angle_r <= '0;
    end else begin
      count_r <= count_nxt;
      angle_r <= angle_nxt;
    end
  end

endmodule

[design/rsg_sine.sv]
`timescale 1ns / 1ps

module rsg_sine #(
  parameter int PIXELS_PER_UNIT = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [7:0]  k
);
  import rsg_pkg::*;

  localparam logic signed [31:0] HORNER_C [2:5] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

  // Divide by 65536, rounding toward zero
  function automatic logic signed [31:0] tdiv16(input logic signed [49:0] p);
    logic signed [49:0] b;
    b = p + (p[49] ? 50'sd65535 : 50'sd0);
    return 32'(b >>> 16);
  endfunction

  logic [1:0]         q;
  logic [14:0]        rr;
  logic [16:0]        u_c;
  logic [33:0]        sq;

  logic [16:0]        u_r   [1:5];
  logic [16:0]        u2_r  [1:4];
  logic               neg_r [1:6];
  logic signed [31:0] acc_r [2:5];
  logic signed [49:0] hprod [2:5];
  logic signed [31:0] acc_nxt [2:5];
  logic signed [49:0] fprod;
  logic signed [31:0] s_c;
  logic [30:0]        s_r;
  logic [39:0]        kp;
  logic [6:0]         mag;
  logic signed [7:0]  k_r;

  // Fold the angle into the first quadrant
  assign q   = angle[15:14];
  assign rr  = q[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign u_c = {rr, 2'b00};
  assign sq  = 34'(u_c) * 34'(u_c);

  always_comb begin
    hprod[2] = 50'(SIN_C9 * $signed({1'b0, u2_r[1]}));
    for (int i = 3; i <= 5; i++) begin
      hprod[i] = 50'(acc_r[i-1] * $signed({1'b0, u2_r[i-1]}));
    end
    for (int i = 2; i <= 5; i++) begin
      acc_nxt[i] = HORNER_C[i] + tdiv16(hprod[i]);
    end
    fprod = 50'(acc_r[5] * $signed({1'b0, u_r[5]}));
    s_c   = tdiv16(fprod);
  end

  assign kp  = 40'(s_r) * 40'(PIXELS_PER_UNIT) + (40'd1 << 30 >> 1);
  assign mag = kp[36:30];

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[1]   <= u_c;
      u2_r[1]  <= sq[32:16];
      neg_r[1] <= q[1];
      for (int i = 2; i <= 5; i++) begin
        u_r[i] <= u_r[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        u2_r[i] <= u2_r[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      s_r <= s_c[31] ? '0 : s_c[30:0];
      k_r <= neg_r[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign k = k_r;

endmodule

[design/rsg_back.sv]
`timescale 1ns / 1ps

module rsg_back #(
  parameter int PIXELS_PER_UNIT = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsg_pkg::rsg_item_t  head_item,
  input  logic                head_valid,
  output logic                pop,
  input  logic [10:0]         grid_center,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_point_valid,
  output logic signed [13:0]  out_point_x,
  output logic signed [13:0]  out_point_y,
  output logic                out_nearest_found,
  output logic [11:0]         out_nearest_index,
  output logic signed [13:0]  out_nearest_x,
  output logic signed [13:0]  out_nearest_y,
  output logic [15:0]         out_nearest_distance,
  output logic                out_scan_done
);
  import rsg_pkg::*;

  localparam int DEPTH = 9;

  function automatic logic signed [13:0] place(input logic [10:0] gc,
                                               input logic signed [24:0] prod);
    logic signed [26:0] v;
    logic signed [26:0] p;
    v = $signed({8'b0, gc, 8'b0}) - 27'(prod);
    p = (v + (v[26] ? 27'sd255 : 27'sd0)) >>> 8;
    if (p > 27'sd8191) begin
      return 14'sd8191;
    end else if (p < -27'sd8192) begin
      return -14'sd8192;
    end
    return 14'(p);
  endfunction

  logic                en;
  logic                v_r    [1:DEPTH];
  rsg_item_t           side_r [1:DEPTH];
  logic signed [7:0]   k_cos, k_sin;
  logic signed [24:0]  prod_x_r, prod_y_r;
  logic signed [13:0]  px_r, py_r;

  logic                best_seen_r, seen_nxt;
  logic [15:0]         best_dist_r, dist_nxt;
  logic [11:0]         best_idx_r, idx_nxt;
  logic signed [13:0]  best_x_r, x_nxt;
  logic signed [13:0]  best_y_r, y_nxt;
  logic                out_valid_r;
  rsg_item_t           tail;

  // Whole pipe advances together; hold everything while a result waits
  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_valid;

  rsg_sine #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT)) u_cos (
    .clk   (clk),
    .en    (en),
    .angle (16'(head_item.angle + 16'h4000)),
    .k     (k_cos)
  );

  rsg_sine #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT)) u_sin (
    .clk   (clk),
    .en    (en),
    .angle (head_item.angle),
    .k     (k_sin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= DEPTH; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[1] <= pop;
      for (int i = 2; i <= DEPTH; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= head_item;
      for (int i = 2; i <= DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
      prod_x_r <= 25'($signed({1'b0, side_r[7].distance}) * k_cos);
      prod_y_r <= 25'($signed({1'b0, side_r[7].distance}) * k_sin);
      px_r     <= side_r[8].in_window ? place(grid_center, prod_x_r) : '0;
      py_r     <= side_r[8].in_window ? place(grid_center, prod_y_r) : '0;
    end
  end

  // First strict minimum wins; ties keep the stored point
  assign tail = side_r[DEPTH];

  always_comb begin
    seen_nxt = best_seen_r;
    dist_nxt = best_dist_r;
    idx_nxt  = best_idx_r;
    x_nxt    = best_x_r;
    y_nxt    = best_y_r;
    if (tail.in_window && (!best_seen_r || (tail.distance < best_dist_r))) begin
      seen_nxt = 1'b1;
      dist_nxt = tail.distance;
      idx_nxt  = tail.index;
      x_nxt    = px_r;
      y_nxt    = py_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[DEPTH];
      if (v_r[DEPTH]) begin
        best_seen_r <= tail.last ? 1'b0 : seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[DEPTH]) begin
      best_dist_r          <= dist_nxt;
      best_idx_r           <= idx_nxt;
      best_x_r             <= x_nxt;
      best_y_r             <= y_nxt;
      out_point_valid      <= tail.in_window;
      out_point_x          <= px_r;
      out_point_y          <= py_r;
      out_nearest_found    <= seen_nxt;
      out_nearest_index    <= seen_nxt ? idx_nxt : '0;
      out_nearest_x        <= seen_nxt ? x_nxt : '0;
      out_nearest_y        <= seen_nxt ? y_nxt : '0;
      out_nearest_distance <= seen_nxt ? dist_nxt : '0;
      out_scan_done        <= tail.last;
    end
  end

  assign out_valid = out_valid_r;

  a_drop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_point_x == 14'sd0 && out_point_y == 14'sd0)
    else $error("dropped sample carries a nonzero point");

  a_kept_found : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid |-> out_nearest_found)
    else $error("kept sample without a nearest point");

  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nearest_found |-> out_nearest_distance == 16'd0 &&
      out_nearest_index == 12'd0)
    else $error("nearest fields not cleared while none found");

  a_scan_reset : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> !best_seen_r)
    else $error("nearest tracking not restarted after scan end");

endmodule

[design/range_scan_to_grid_nearest.sv]
`timescale 1ns / 1ps

// Range scan to grid: one Q8.8 range sample per transaction goes in, one
// result per transaction comes out, in order. A sample inside the window
// [range_low, range_high] is placed at x = grid_center - d*kc and
// y = grid_center - d*ks (truncated toward zero, saturated to 14 bits),
// where kc and ks are PIXELS_PER_UNIT times cos and sin of the sample's
// angle, rounded to integers; a sample outside the window reports point
// 0,0 with point_valid low. The sample angle starts at angle_start and
// advances by angle_step per sample. Every result also carries the first
// strict nearest point of the scan so far; a sample with scan_last set
// closes the scan and restarts index, angle and nearest tracking.
// Throughput is one transaction per clock while out_ready stays high.
// A sample passes through the input queue, the sine/cosine polynomial
// pipeline (one multiply per stage), the distance product register, the
// placement register and the nearest-point output register. The back end
// stalls as a whole while a result waits with out_ready low; the
// four-entry queue keeps in_ready high meanwhile until it fills.
// Registers (APB, 32-bit words): 0x00 range_low, 0x04 range_high,
// 0x08 angle_start, 0x0C angle_step, 0x10 grid_center. Change them only
// while no transaction is in flight; writing angle_start at the start of
// a scan, while no sample is accepted, takes effect on the next sample.
module range_scan_to_grid_nearest #(
  parameter int MAX_SAMPLES     = 4096,
  parameter int PIXELS_PER_UNIT = 10
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_distance,
  input  logic               in_scan_last,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [13:0] out_point_x,
  output logic signed [13:0] out_point_y,
  output logic               out_nearest_found,
  output logic [11:0]        out_nearest_index,
  output logic signed [13:0] out_nearest_x,
  output logic signed [13:0] out_nearest_y,
  output logic [15:0]        out_nearest_distance,
  output logic               out_scan_done,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rsg_pkg::*;

  logic [DIST_W-1:0] range_low_r, range_high_r;
  logic [ANG_W-1:0]  angle_start_r, angle_step_r;
  logic [CTR_W-1:0]  grid_center_r;

  logic              cfg_wr;
  rsg_cfg_t          cfg;
  rsg_start_t        start_wr;

  logic              push, pop, q_full, q_not_empty;
  rsg_item_t         push_item, head_item;

  // Register file: write on the access phase, pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      range_high_r  <= '1;
      angle_start_r <= '0;
      angle_step_r  <= '0;
      grid_center_r <= CTR_W'(400);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_RANGE_LOW:   range_low_r   <= pwdata[DIST_W-1:0];
        REG_RANGE_HIGH:  range_high_r  <= pwdata[DIST_W-1:0];
        REG_ANGLE_START: angle_start_r <= pwdata[ANG_W-1:0];
        REG_ANGLE_STEP:  angle_step_r  <= pwdata[ANG_W-1:0];
        REG_GRID_CENTER: grid_center_r <= pwdata[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RANGE_LOW:   prdata = 32'(range_low_r);
      REG_RANGE_HIGH:  prdata = 32'(range_high_r);
      REG_ANGLE_START: prdata = 32'(angle_start_r);
      REG_ANGLE_STEP:  prdata = 32'(angle_step_r);
      REG_GRID_CENTER: prdata = 32'(grid_center_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.range_low   = range_low_r;
  assign cfg.range_high  = range_high_r;
  assign cfg.angle_step  = angle_step_r;
  assign cfg.grid_center = grid_center_r;

  // A start-angle write also reloads the angle at the head of a scan;
  // otherwise the front picks up the stored value at scan end
  assign start_wr.load  = cfg_wr && (paddr[4:2] == REG_ANGLE_START);
  assign start_wr.value = start_wr.load ? pwdata[ANG_W-1:0] : angle_start_r;

  // Front: accept, window-classify, tag index and angle
  rsg_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_distance  (in_distance),
    .in_scan_last (in_scan_last),
    .cfg          (cfg),
    .start_wr     (start_wr),
    .queue_full   (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple the front from the back-end stall
  rsg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: trig pipeline, placement, nearest tracking, output register
  rsg_back #(.PIXELS_PER_UNIT(PIXELS_PER_UNIT)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_item            (head_item),
    .head_valid           (q_not_empty),
    .pop                  (pop),
    .grid_center          (grid_center_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_point_valid      (out_point_valid),
    .out_point_x          (out_point_x),
    .out_point_y          (out_point_y),
    .out_nearest_found    (out_nearest_found),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_x        (out_nearest_x),
    .out_nearest_y        (out_nearest_y),
    .out_nearest_distance (out_nearest_distance),
    .out_scan_done        (out_scan_done)
  );

endmodule
